// File: design/i80q_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 8080-style bus master task queue.
// No dependencies; used by every module of the block.
package i80q_pkg;

  localparam int QueueDepthDefault = 8;
  localparam int AddrBits          = 16;
  localparam int FieldW            = 16;
  localparam int ByteW             = 8;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // request as classified by the front part
  typedef struct packed {
    cmd_e              command;
    logic              is_read;
    logic              is_data;
    logic [FieldW-1:0] buffer_base;
    logic [FieldW-1:0] transfer_length;
    logic [ByteW-1:0]  buffer_byte;
    logic [ByteW-1:0]  bus_byte;
  } cmd_t;

  // one stored transfer task
  typedef struct packed {
    logic              is_read;
    logic              is_data;
    logic [FieldW-1:0] base;
    logic [FieldW-1:0] length;
  } entry_t;

  typedef struct packed {
    logic              accepted;
    logic              cycle_done;
    logic              rs_level;
    logic              cycle_is_read;
    logic [FieldW-1:0] buffer_address;
    logic [ByteW-1:0]  drive_byte;
    logic [ByteW-1:0]  read_byte;
    logic              task_finished;
    logic              finished_was_read;
    logic [FieldW-1:0] finished_base;
    logic [FieldW-1:0] finished_length;
  } res_t;

endpackage

// File: design/i80q_front.sv
`timescale 1ns / 1ps
// Front part: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on i80q_pkg.
module i80q_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic                            is_read_i,
  input  logic                            is_data_i,
  input  logic [i80q_pkg::FieldW-1:0]     buffer_base_i,
  input  logic [i80q_pkg::FieldW-1:0]     transfer_length_i,
  input  logic [i80q_pkg::ByteW-1:0]      buffer_byte_i,
  input  logic [i80q_pkg::ByteW-1:0]      bus_byte_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output i80q_pkg::cmd_t                  cmd_o
);

  i80q_pkg::cmd_t fifo_q [2];
  i80q_pkg::cmd_t new_cmd;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    new_cmd.command         = i80q_pkg::cmd_e'(command_i);
    new_cmd.is_read         = is_read_i;
    new_cmd.is_data         = is_data_i;
    new_cmd.buffer_base     = buffer_base_i;
    new_cmd.transfer_length = transfer_length_i;
    new_cmd.buffer_byte     = buffer_byte_i;
    new_cmd.bus_byte        = bus_byte_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// File: design/i80q_back.sv
`timescale 1ns / 1ps
// Back part: task store, head/tail pointers, offset counter and the result register.
// Depends on i80q_pkg.
module i80q_back #(
  parameter int QueueDepth = i80q_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  i80q_pkg::cmd_t  cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i80q_pkg::res_t  res_o
);

  localparam int IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(QueueDepth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

  i80q_pkg::entry_t task_mem [QueueDepth];
  i80q_pkg::entry_t entry_q;
  i80q_pkg::entry_t wr_entry;
  i80q_pkg::state_e state_q, state_d;
  i80q_pkg::cmd_t   cur_q, cur_d;
  i80q_pkg::res_t   res_q, res_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [i80q_pkg::FieldW-1:0] offset_q, offset_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free, start, mem_we;
  logic [i80q_pkg::FieldW:0]   addr_sum, next_off;
  logic [i80q_pkg::FieldW-1:0] addr_wrap;
  logic             finished;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == i80q_pkg::ST_IDLE) && out_free;
  assign start       = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign addr_sum = {1'b0, entry_q.base} + {1'b0, offset_q};
  assign next_off = {1'b0, offset_q} + {{i80q_pkg::FieldW{1'b0}}, 1'b1};
  assign finished = (next_off >= {1'b0, entry_q.length});

  // drop address bits above the bus address width
  always_comb begin
    for (int b = 0; b < i80q_pkg::FieldW; b++) begin
      addr_wrap[b] = (b < i80q_pkg::AddrBits) ? addr_sum[b] : 1'b0;
    end
  end

  always_comb begin
    wr_entry.is_read = cmd_i.is_read;
    wr_entry.is_data = cmd_i.is_data;
    wr_entry.base    = cmd_i.buffer_base;
    wr_entry.length  = cmd_i.transfer_length;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      i80q_pkg::ST_IDLE: begin
        if (start && cmd_i.command == i80q_pkg::CMD_TICK && count_q != '0) begin
          state_d = i80q_pkg::ST_EXEC;
        end
      end
      i80q_pkg::ST_EXEC: state_d = i80q_pkg::ST_IDLE;
      default:           state_d = i80q_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    offset_d    = offset_q;
    cur_d       = cur_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    case (state_q)
      i80q_pkg::ST_IDLE: begin
        if (start) begin
          cur_d = cmd_i;
          if (cmd_i.command == i80q_pkg::CMD_ENQUEUE) begin
            res_d       = '0;
            out_valid_d = 1'b1;
            if (count_q != DepthCnt) begin
              mem_we         = 1'b1;
              res_d.accepted = 1'b1;
              tail_d         = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
              count_d        = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            res_d       = '0;
            out_valid_d = 1'b1;
          end
        end
      end
      i80q_pkg::ST_EXEC: begin
        res_d                = '0;
        out_valid_d          = 1'b1;
        res_d.cycle_done     = 1'b1;
        res_d.rs_level       = entry_q.is_data;
        res_d.cycle_is_read  = entry_q.is_read;
        res_d.buffer_address = addr_wrap;
        if (entry_q.is_read) begin
          res_d.read_byte = cur_q.bus_byte;
        end else begin
          res_d.drive_byte = cur_q.buffer_byte;
        end
        if (finished) begin
          res_d.task_finished     = 1'b1;
          res_d.finished_was_read = entry_q.is_read;
          res_d.finished_base     = entry_q.base;
          res_d.finished_length   = entry_q.length;
          offset_d                = '0;
          head_d                  = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
          count_d                 = count_q - CntW'(1);
        end else begin
          offset_d = next_off[i80q_pkg::FieldW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i80q_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  // task store: one write port at the tail, one registered read port at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      task_mem[tail_q] <= wr_entry;
    end
    entry_q <= task_mem[head_q];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("task count above queue depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   mem_we |-> count_q != DepthCnt)
    else $error("task written into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == i80q_pkg::ST_EXEC |-> count_q != '0 && !out_valid_q)
    else $error("bus access started without a task or a free result slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == i80q_pkg::ST_EXEC |=> state_q == i80q_pkg::ST_IDLE && out_valid_q)
    else $error("bus access did not deliver a result");

endmodule

// File: design/i80_bus_master_task_queue.sv
`timescale 1ns / 1ps
// 8080-style parallel bus master with a bounded queue of transfer tasks.
// Results: an enqueue, or a tick on an empty queue, writes the result register when the back
//   part takes it; a tick that performs a bus access passes the EXEC state first, set by the
//   registered read port of the task store. Throughput: one enqueue per cycle while the receiver
//   takes each result; no new request is taken in EXEC. Reset clears pointers, counts and
//   handshakes; the task store is not cleared. Depends on i80q_pkg, i80q_front and i80q_back.
module i80_bus_master_task_queue #(
  parameter int QueueDepth = i80q_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic                        is_read_i,
  input  logic                        is_data_i,
  input  logic [i80q_pkg::FieldW-1:0] buffer_base_i,
  input  logic [i80q_pkg::FieldW-1:0] transfer_length_i,
  input  logic [i80q_pkg::ByteW-1:0]  buffer_byte_i,
  input  logic [i80q_pkg::ByteW-1:0]  bus_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic                        cycle_done_o,
  output logic                        rs_level_o,
  output logic                        cycle_is_read_o,
  output logic [i80q_pkg::FieldW-1:0] buffer_address_o,
  output logic [i80q_pkg::ByteW-1:0]  drive_byte_o,
  output logic [i80q_pkg::ByteW-1:0]  read_byte_o,
  output logic                        task_finished_o,
  output logic                        finished_was_read_o,
  output logic [i80q_pkg::FieldW-1:0] finished_base_o,
  output logic [i80q_pkg::FieldW-1:0] finished_length_o
);

  // request queue between the front and the back part
  logic           cmd_valid;
  logic           cmd_ready;
  i80q_pkg::cmd_t cmd;
  i80q_pkg::res_t res;

  // Accept and classify requests; hold up to two of them while the back part is busy.
  i80q_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .is_read_i         (is_read_i),
    .is_data_i         (is_data_i),
    .buffer_base_i     (buffer_base_i),
    .transfer_length_i (transfer_length_i),
    .buffer_byte_i     (buffer_byte_i),
    .bus_byte_i        (bus_byte_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_ready_i       (cmd_ready),
    .cmd_o             (cmd)
  );

  // Store tasks, perform one bus access per tick on a non-empty queue and hold the result until it is taken.
  i80q_back #(
    .QueueDepth (QueueDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // Spread the result register onto the ports.
  assign accepted_o          = res.accepted;
  assign cycle_done_o        = res.cycle_done;
  assign rs_level_o          = res.rs_level;
  assign cycle_is_read_o     = res.cycle_is_read;
  assign buffer_address_o    = res.buffer_address;
  assign drive_byte_o        = res.drive_byte;
  assign read_byte_o         = res.read_byte;
  assign task_finished_o     = res.task_finished;
  assign finished_was_read_o = res.finished_was_read;
  assign finished_base_o     = res.finished_base;
  assign finished_length_o   = res.finished_length;

endmodule

// File: verif/tb_i80_bus_master_task_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for i80_bus_master_task_queue: enqueue and tick requests are sent
// through the valid/ready port and every result is checked against an in-bench task queue model.
// Depends on i80q_pkg and the RTL of the block only.
module tb_i80_bus_master_task_queue;

  localparam int QueueDepth = i80q_pkg::QueueDepthDefault;
  localparam int FieldW     = i80q_pkg::FieldW;
  localparam int ByteW      = i80q_pkg::ByteW;
  localparam int QuietLimit = 2000;
  localparam int MaxReports = 10;
  localparam int RandomPerPhase = 280;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = 1'b0;
  logic              is_read = 1'b0;
  logic              is_data = 1'b0;
  logic [FieldW-1:0] buffer_base = '0;
  logic [FieldW-1:0] transfer_length = '0;
  logic [ByteW-1:0]  buffer_byte = '0;
  logic [ByteW-1:0]  bus_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              accepted;
  logic              cycle_done;
  logic              rs_level;
  logic              cycle_is_read;
  logic [FieldW-1:0] buffer_address;
  logic [ByteW-1:0]  drive_byte;
  logic [ByteW-1:0]  read_byte;
  logic              task_finished;
  logic              finished_was_read;
  logic [FieldW-1:0] finished_base;
  logic [FieldW-1:0] finished_length;

  // model of the transfer queue and the head task's progress
  i80q_pkg::entry_t model_tasks [QueueDepth];
  int     model_head = 0;
  int     model_tail = 0;
  int     model_count = 0;
  int     model_offset = 0;

  i80q_pkg::res_t pending_results[$];

  int     idle_pct = 0;
  int     stall_pct = 0;
  int     sent_count = 0;
  int     checked_count = 0;
  int     finished_count = 0;
  int     refused_count = 0;
  int     empty_tick_count = 0;
  int     mismatch_count = 0;

  i80_bus_master_task_queue u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .command_i           (command),
    .is_read_i           (is_read),
    .is_data_i           (is_data),
    .buffer_base_i       (buffer_base),
    .transfer_length_i   (transfer_length),
    .buffer_byte_i       (buffer_byte),
    .bus_byte_i          (bus_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .accepted_o          (accepted),
    .cycle_done_o        (cycle_done),
    .rs_level_o          (rs_level),
    .cycle_is_read_o     (cycle_is_read),
    .buffer_address_o    (buffer_address),
    .drive_byte_o        (drive_byte),
    .read_byte_o         (read_byte),
    .task_finished_o     (task_finished),
    .finished_was_read_o (finished_was_read),
    .finished_base_o     (finished_base),
    .finished_length_o   (finished_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Work out the result of one accepted request and advance the queue model.
  function automatic i80q_pkg::res_t predict_bus_result(input i80q_pkg::cmd_e cmd,
      input logic rd, input logic dat,
      input logic [FieldW-1:0] base, input logic [FieldW-1:0] len,
      input logic [ByteW-1:0] bbyte, input logic [ByteW-1:0] busb);
    i80q_pkg::res_t   r;
    i80q_pkg::entry_t head;
    r = '0;
    if (cmd == i80q_pkg::CMD_ENQUEUE) begin
      // a full queue refuses the task and keeps its state
      if (model_count < QueueDepth) begin
        model_tasks[model_tail] = '{is_read: rd, is_data: dat, base: base, length: len};
        model_tail = (model_tail + 1) % QueueDepth;
        model_count++;
        r.accepted = 1'b1;
      end
    end else if (model_count != 0) begin
      head = model_tasks[model_head];
      r.cycle_done     = 1'b1;
      r.rs_level       = head.is_data;
      r.cycle_is_read  = head.is_read;
      r.buffer_address = head.base + model_offset[FieldW-1:0];
      if (head.is_read) begin
        r.read_byte = busb;
      end else begin
        r.drive_byte = bbyte;
      end
      // a zero-length task still makes its one access and then finishes
      if (model_offset + 1 >= int'(head.length)) begin
        r.task_finished     = 1'b1;
        r.finished_was_read = head.is_read;
        r.finished_base     = head.base;
        r.finished_length   = head.length;
        model_offset = 0;
        model_head   = (model_head + 1) % QueueDepth;
        model_count--;
      end else begin
        model_offset++;
      end
    end
    return r;
  endfunction

  // Present one request, hold it until accepted, then record what it should produce.
  task automatic send_request(input i80q_pkg::cmd_e cmd, input logic rd, input logic dat,
      input logic [FieldW-1:0] base, input logic [FieldW-1:0] len,
      input logic [ByteW-1:0] bbyte, input logic [ByteW-1:0] busb);
    i80q_pkg::res_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    command         <= cmd;
    is_read         <= rd;
    is_data         <= dat;
    buffer_base     <= base;
    transfer_length <= len;
    buffer_byte     <= bbyte;
    bus_byte        <= busb;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    want = predict_bus_result(cmd, rd, dat, base, len, bbyte, busb);
    pending_results.push_back(want);
    sent_count++;
    if (cmd == i80q_pkg::CMD_ENQUEUE && !want.accepted) refused_count++;
    if (cmd == i80q_pkg::CMD_TICK && !want.cycle_done) empty_tick_count++;
    if (want.task_finished) finished_count++;
  endtask

  // Enqueue with random tick fields, and tick with random enqueue fields: the block ignores them.
  task automatic send_enqueue(input logic rd, input logic dat, input logic [FieldW-1:0] base,
      input logic [FieldW-1:0] len);
    send_request(i80q_pkg::CMD_ENQUEUE, rd, dat, base, len, ByteW'($urandom),
                 ByteW'($urandom));
  endtask

  task automatic send_tick(input logic [ByteW-1:0] bbyte, input logic [ByteW-1:0] busb);
    send_request(i80q_pkg::CMD_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 FieldW'($urandom), FieldW'($urandom), bbyte, busb);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic drain_queue();
    while (model_count != 0) send_tick(ByteW'($urandom), ByteW'($urandom));
  endtask

  // Empty-queue ticks, zero-length tasks, address wrap and both access directions.
  task automatic test_directed_accesses();
    send_tick(8'h00, 8'h00);
    send_tick(8'hFF, 8'hFF);
    send_enqueue(1'b0, 1'b0, 16'h0000, 16'h0000);
    send_tick(8'hFF, 8'h00);
    send_enqueue(1'b1, 1'b1, 16'hFFFF, 16'h0003);
    send_tick(8'h12, 8'h00);
    send_tick(8'h34, 8'hFF);
    send_tick(8'h56, 8'h5A);
    send_enqueue(1'b0, 1'b1, 16'hFFFE, 16'h0002);
    send_tick(8'h00, 8'hC3);
    send_tick(8'h80, 8'h3C);
  endtask

  // Fill the queue from idle, get refused twice, then drain it and tick once more on empty.
  task automatic test_queue_full();
    int i;
    wait_results_drained();
    for (i = 0; i < QueueDepth; i++) begin
      send_enqueue(i[0], i[1], FieldW'($urandom), FieldW'(i % 2));
    end
    send_enqueue(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    send_enqueue(1'b0, 1'b0, 16'h0000, 16'h0000);
    drain_queue();
    send_tick(ByteW'($urandom), ByteW'($urandom));
  endtask

  // Random traffic; the enqueue share swings between bursts so the queue fills and drains.
  task automatic test_random_traffic(input int idle, input int stall, input int n);
    int i;
    int enq_pct;
    logic [FieldW-1:0] len;
    idle_pct  = idle;
    stall_pct = stall;
    enq_pct   = 25;
    for (i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 15;
          1: enq_pct = 22;
          default: enq_pct = 40;
        endcase
      end
      if ($urandom_range(99) < enq_pct) begin
        if ($urandom_range(19) == 0) begin
          len = FieldW'($urandom_range(40, 8));
        end else begin
          len = FieldW'($urandom_range(7));
        end
        send_enqueue(1'($urandom_range(1)), 1'($urandom_range(1)), FieldW'($urandom), len);
      end else begin
        send_tick(ByteW'($urandom), ByteW'($urandom));
      end
    end
  endtask

  // Run one longer read task across the top of the address space, then a zero-length write.
  task automatic test_long_transfer();
    idle_pct  = 0;
    stall_pct = 0;
    drain_queue();
    send_enqueue(1'b1, 1'b1, 16'hFFE0, 16'h0030);
    send_enqueue(1'b0, 1'b0, 16'h0000, 16'h0000);
    drain_queue();
  endtask

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_field(input string name, input logic [FieldW-1:0] want_v,
      input logic [FieldW-1:0] got_v);
    if (want_v !== got_v) $display("  %s: expected %h, got %h", name, want_v, got_v);
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin : check_results
    i80q_pkg::res_t got;
    i80q_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{accepted: accepted, cycle_done: cycle_done, rs_level: rs_level,
              cycle_is_read: cycle_is_read, buffer_address: buffer_address,
              drive_byte: drive_byte, read_byte: read_byte, task_finished: task_finished,
              finished_was_read: finished_was_read, finished_base: finished_base,
              finished_length: finished_length};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) $display("ERROR: result with none expected: %p", got);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("ERROR: result %0d differs", checked_count);
            report_field("accepted", FieldW'(want.accepted), FieldW'(got.accepted));
            report_field("cycle_done", FieldW'(want.cycle_done), FieldW'(got.cycle_done));
            report_field("rs_level", FieldW'(want.rs_level), FieldW'(got.rs_level));
            report_field("cycle_is_read", FieldW'(want.cycle_is_read),
                         FieldW'(got.cycle_is_read));
            report_field("buffer_address", want.buffer_address, got.buffer_address);
            report_field("drive_byte", FieldW'(want.drive_byte), FieldW'(got.drive_byte));
            report_field("read_byte", FieldW'(want.read_byte), FieldW'(got.read_byte));
            report_field("task_finished", FieldW'(want.task_finished),
                         FieldW'(got.task_finished));
            report_field("finished_was_read", FieldW'(want.finished_was_read),
                         FieldW'(got.finished_was_read));
            report_field("finished_base", want.finished_base, got.finished_base);
            report_field("finished_length", want.finished_length, got.finished_length);
          end
        end
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("i80_bus_master_task_queue test failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_accesses();
    test_queue_full();
    test_random_traffic(0, 0, RandomPerPhase);
    test_random_traffic(71, 0, RandomPerPhase);
    test_random_traffic(0, 71, RandomPerPhase);
    test_random_traffic(27, 27, RandomPerPhase);
    test_long_transfer();

    wait_results_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests: %0d refused enqueues, %0d ticks on an empty queue,",
             sent_count, refused_count, empty_tick_count);
    $display("%0d tasks done; checked %0d results, %0d mismatches",
             finished_count, checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("i80_bus_master_task_queue test passed");
    end else begin
      $display("i80_bus_master_task_queue test failed");
    end
    $finish;
  end

endmodule
